[rtl/qrv_pkg.sv]
`timescale 1ns / 1ps

package qrv_pkg;

  localparam int QuatW    = 16;
  localparam int VecW     = 16;
  localparam int ProdQW   = 2 * QuatW;
  localparam int TermW    = ProdQW + 2;
  localparam int ProdW    = TermW + VecW;
  localparam int AccW     = ProdW + 2;
  localparam int FracBits = 28;
  localparam int VecN     = 3;
  localparam int MatN     = VecN * VecN;
  localparam int CfgIdxW  = 2;
  localparam int RndW     = AccW - FracBits;

  typedef logic signed [QuatW-1:0]  quat_t;
  typedef logic signed [ProdQW-1:0] qprod_t;
  typedef logic signed [TermW-1:0]  term_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic signed [AccW-1:0]   acc_t;
  typedef logic signed [VecW-1:0]   vec_t;
  typedef term_t [MatN-1:0]         mat_t;

  typedef enum logic [CfgIdxW-1:0] {
    CfgQuatX = 2'd0,
    CfgQuatY = 2'd1,
    CfgQuatZ = 2'd2,
    CfgQuatW = 2'd3
  } cfg_idx_e;

  localparam quat_t QuatXRst = 16'sd0;
  localparam quat_t QuatYRst = 16'sd0;
  localparam quat_t QuatZRst = 16'sd0;
  localparam quat_t QuatWRst = 16'sd16384;

  localparam term_t TermOne  = term_t'(1) <<< FracBits;
  localparam acc_t  AccHalf  = acc_t'(1) <<< (FracBits - 1);
  localparam logic signed [RndW-1:0] SatMax = RndW'(32767);
  localparam logic signed [RndW-1:0] SatMin = -RndW'(32768);

  function automatic term_t ext_term(input qprod_t a);
    return term_t'(a);
  endfunction

  function automatic acc_t ext_prod(input prod_t a);
    return acc_t'(a);
  endfunction

endpackage

[rtl/qrv_matrix.sv]
`timescale 1ns / 1ps

module qrv_matrix (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [qrv_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [qrv_pkg::QuatW-1:0]     cfg_data_i,
  output qrv_pkg::mat_t                 mat_o,
  output logic                          busy_o
);

  localparam logic [1:0] SettleCycles = 2'd2;

  qrv_pkg::quat_t  qx_q, qy_q, qz_q, qw_q;
  qrv_pkg::qprod_t xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
  qrv_pkg::mat_t   mat_d, mat_q;
  logic [1:0]      settle_d, settle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qx_q     <= qrv_pkg::QuatXRst;
      qy_q     <= qrv_pkg::QuatYRst;
      qz_q     <= qrv_pkg::QuatZRst;
      qw_q     <= qrv_pkg::QuatWRst;
      settle_q <= SettleCycles;
    end else begin
      settle_q <= settle_d;
      if (cfg_we_i) begin
        case (qrv_pkg::cfg_idx_e'(cfg_index_i))
          qrv_pkg::CfgQuatX: qx_q <= cfg_data_i;
          qrv_pkg::CfgQuatY: qy_q <= cfg_data_i;
          qrv_pkg::CfgQuatZ: qz_q <= cfg_data_i;
          qrv_pkg::CfgQuatW: qw_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    if (cfg_we_i) begin
      settle_d = SettleCycles;
    end else if (settle_q != 2'd0) begin
      settle_d = settle_q - 2'd1;
    end else begin
      settle_d = settle_q;
    end
  end

  // products of quaternion components
  always_ff @(posedge clk_i) begin
    xx_q <= qx_q * qx_q;
    yy_q <= qy_q * qy_q;
    zz_q <= qz_q * qz_q;
    xy_q <= qx_q * qy_q;
    xz_q <= qx_q * qz_q;
    yz_q <= qy_q * qz_q;
    wx_q <= qw_q * qx_q;
    wy_q <= qw_q * qy_q;
    wz_q <= qw_q * qz_q;
  end

  always_comb begin
    mat_d[0] = qrv_pkg::TermOne
             - ((qrv_pkg::ext_term(yy_q) + qrv_pkg::ext_term(zz_q)) <<< 1);
    mat_d[1] = (qrv_pkg::ext_term(xy_q) - qrv_pkg::ext_term(wz_q)) <<< 1;
    mat_d[2] = (qrv_pkg::ext_term(xz_q) + qrv_pkg::ext_term(wy_q)) <<< 1;
    mat_d[3] = (qrv_pkg::ext_term(xy_q) + qrv_pkg::ext_term(wz_q)) <<< 1;
    mat_d[4] = qrv_pkg::TermOne
             - ((qrv_pkg::ext_term(xx_q) + qrv_pkg::ext_term(zz_q)) <<< 1);
    mat_d[5] = (qrv_pkg::ext_term(yz_q) - qrv_pkg::ext_term(wx_q)) <<< 1;
    mat_d[6] = (qrv_pkg::ext_term(xz_q) - qrv_pkg::ext_term(wy_q)) <<< 1;
    mat_d[7] = (qrv_pkg::ext_term(yz_q) + qrv_pkg::ext_term(wx_q)) <<< 1;
    mat_d[8] = qrv_pkg::TermOne
             - ((qrv_pkg::ext_term(xx_q) + qrv_pkg::ext_term(yy_q)) <<< 1);
  end

  always_ff @(posedge clk_i) begin
    mat_q <= mat_d;
  end

  assign mat_o  = mat_q;
  assign busy_o = (settle_q != 2'd0);

  a_cfg_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> busy_o ##1 busy_o)
    else $error("matrix not held busy after a register write");

endmodule

[rtl/qrv_datapath.sv]
`timescale 1ns / 1ps

module qrv_datapath (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      in_valid_i,
  output logic                                      in_ready_o,
  input  logic [qrv_pkg::VecN*qrv_pkg::VecW-1:0]    in_data_i,
  input  qrv_pkg::mat_t                             mat_i,
  input  logic                                      busy_i,
  output logic                                      out_valid_o,
  input  logic                                      out_ready_i,
  output logic [qrv_pkg::VecN*qrv_pkg::VecW-1:0]    out_data_o,
  output logic                                      out_sat_o
);

  logic en1, en2, en3;
  logic s1_valid_q, s2_valid_q, s3_valid_q;

  qrv_pkg::vec_t  vec    [qrv_pkg::VecN];
  qrv_pkg::prod_t prod_d [qrv_pkg::MatN];
  qrv_pkg::prod_t prod_q [qrv_pkg::MatN];
  qrv_pkg::acc_t  acc_d  [qrv_pkg::VecN];
  qrv_pkg::acc_t  acc_q  [qrv_pkg::VecN];
  logic [qrv_pkg::VecN*qrv_pkg::VecW-1:0] rot_d, rot_q;
  logic [qrv_pkg::VecN-1:0] clip;
  logic sat_q;

  assign en3        = !s3_valid_q || out_ready_i;
  assign en2        = !s2_valid_q || en3;
  assign en1        = !s1_valid_q || en2;
  assign in_ready_o = en1 && !busy_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (en1) begin
        s1_valid_q <= in_valid_i && in_ready_o;
      end
      if (en2) begin
        s2_valid_q <= s1_valid_q;
      end
      if (en3) begin
        s3_valid_q <= s2_valid_q;
      end
    end
  end

  always_comb begin
    for (int c = 0; c < qrv_pkg::VecN; c++) begin
      vec[c] = in_data_i[c*qrv_pkg::VecW +: qrv_pkg::VecW];
    end
    for (int k = 0; k < qrv_pkg::MatN; k++) begin
      prod_d[k] = $signed(mat_i[k]) * vec[k % qrv_pkg::VecN];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      prod_q <= prod_d;
    end
  end

  always_comb begin
    for (int r = 0; r < qrv_pkg::VecN; r++) begin
      acc_d[r] = qrv_pkg::ext_prod(prod_q[r*qrv_pkg::VecN])
               + qrv_pkg::ext_prod(prod_q[r*qrv_pkg::VecN + 1])
               + qrv_pkg::ext_prod(prod_q[r*qrv_pkg::VecN + 2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      acc_q <= acc_d;
    end
  end

  // round half up, then clip to 16 bits
  always_comb begin
    qrv_pkg::acc_t rnd;
    logic signed [qrv_pkg::RndW-1:0] whole;
    for (int r = 0; r < qrv_pkg::VecN; r++) begin
      rnd   = acc_q[r] + qrv_pkg::AccHalf;
      whole = rnd[qrv_pkg::AccW-1:qrv_pkg::FracBits];
      if (whole > qrv_pkg::SatMax) begin
        rot_d[r*qrv_pkg::VecW +: qrv_pkg::VecW] = qrv_pkg::VecW'(qrv_pkg::SatMax);
        clip[r] = 1'b1;
      end else if (whole < qrv_pkg::SatMin) begin
        rot_d[r*qrv_pkg::VecW +: qrv_pkg::VecW] = qrv_pkg::VecW'(qrv_pkg::SatMin);
        clip[r] = 1'b1;
      end else begin
        rot_d[r*qrv_pkg::VecW +: qrv_pkg::VecW] = whole[qrv_pkg::VecW-1:0];
        clip[r] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      rot_q <= rot_d;
      sat_q <= |clip;
    end
  end

  assign out_valid_o = s3_valid_q;
  assign out_data_o  = rot_q;
  assign out_sat_o   = sat_q;

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> s1_valid_q)
    else $error("accepted beat did not enter the first stage");

  a_s2_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && !en2 |=> s2_valid_q)
    else $error("middle stage dropped a beat under stall");

  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !en2 |=> s1_valid_q)
    else $error("first stage dropped a beat under stall");

endmodule

[rtl/quaternion_rotate_vector.sv]
`timescale 1ns / 1ps
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tdata: vec_x, vec_y, vec_z
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata: rot_x, rot_y, rot_z; tuser: saturated
// cfg       in   cfg_valid_i/cfg_ready_o        cfg_index_i, cfg_data_i
//
// One vector per cycle while busy is low and m_axis is not stalled; each beat passes
// the product, sum and rounding registers in turn. Quaternion products and matrix
// terms are two registered stages off the register file; input is held off after
// reset and after each register write while they settle.
// A stall on m_axis holds each stage in place; bubbles still fill.

module quaternion_rotate_vector (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  logic [qrv_pkg::VecN*qrv_pkg::VecW-1:0]  s_axis_tdata,  // vec_x, vec_y, vec_z
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  output logic [qrv_pkg::VecN*qrv_pkg::VecW-1:0]  m_axis_tdata,  // rot_x, rot_y, rot_z
  output logic                                    m_axis_tuser,  // saturated
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [qrv_pkg::CfgIdxW-1:0]             cfg_index_i,
  input  logic [qrv_pkg::QuatW-1:0]               cfg_data_i
);

  qrv_pkg::mat_t mat;
  logic          busy;

  assign cfg_ready_o = 1'b1;

  qrv_matrix u_matrix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .mat_o       (mat),
    .busy_o      (busy)
  );

  qrv_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .mat_i       (mat),
    .busy_i      (busy),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_sat_o   (m_axis_tuser)
  );

endmodule
